// ===== rtl/swss_pkg.sv =====
package swss_pkg;

    localparam int SPEED_W   = 16;
    localparam int ANGLE_W   = 8;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int DEG_W     = 7;
    localparam int MAX_DEG   = 90;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_CAR_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAR_LENGTH = 2'd1;

    // Per-item data that rides alongside the radius and divider stages.
    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [SPEED_W-1:0]        mag;
        logic                      neg;
        logic                      turn_right;
        logic                      bypass;
    } side_t;

endpackage

// ===== rtl/swss_div.sv =====
module swss_div #(
    parameter int DVD_W = 43,
    parameter int DVS_W = 29,
    parameter int Q_W   = 21
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic [Q_W-1:0]   quotient
);

    // Restoring division, one quotient bit per stage. The caller guarantees
    // that the quotient fits in Q_W bits, so the upper dividend bits start
    // out below the divisor.
    logic [DVS_W-1:0] rem_in [0:Q_W-1];
    logic [Q_W-1:0]   lo_in  [0:Q_W-1];
    logic [DVS_W-1:0] dvs_in [0:Q_W-1];
    logic [Q_W-1:0]   q_in   [0:Q_W-1];

    logic [DVS_W-1:0] rem_reg [0:Q_W-2];
    logic [Q_W-1:0]   lo_reg  [0:Q_W-2];
    logic [DVS_W-1:0] dvs_reg [0:Q_W-2];
    logic [Q_W-1:0]   q_reg   [0:Q_W-1];

    assign rem_in[0] = DVS_W'(dividend[DVD_W-1:Q_W]);
    assign lo_in[0]  = dividend[Q_W-1:0];
    assign dvs_in[0] = divisor;
    assign q_in[0]   = '0;

    for (genvar i = 0; i < Q_W; i++) begin : g_stage
        logic [DVS_W:0]   shifted;
        logic [DVS_W:0]   diff;
        logic             ge;
        logic [DVS_W-1:0] rem_next;
        logic [Q_W-1:0]   lo_next;
        logic [Q_W-1:0]   q_next;

        if (i > 0) begin : g_link
            assign rem_in[i] = rem_reg[i-1];
            assign lo_in[i]  = lo_reg[i-1];
            assign dvs_in[i] = dvs_reg[i-1];
            assign q_in[i]   = q_reg[i-1];
        end

        always_comb begin
            shifted  = {rem_in[i], lo_in[i][Q_W-1]};
            diff     = shifted - {1'b0, dvs_in[i]};
            ge       = (shifted >= {1'b0, dvs_in[i]});
            rem_next = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
            lo_next  = {lo_in[i][Q_W-2:0], 1'b0};
            q_next   = {q_in[i][Q_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[i] <= q_next;
            end
        end

        if (i < Q_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    lo_reg[i]  <= lo_next;
                    dvs_reg[i] <= dvs_in[i];
                end
            end
        end
    end

    assign quotient = q_reg[Q_W-1];

endmodule

// ===== rtl/steering_wheel_speed_split.sv =====
// Electronic differential: splits a signed drive speed into rear left and
// rear right wheel speeds from a steering angle, using Ackermann geometry.
// Input items arrive on s_tvalid/s_tready/s_tdata, one result item per input
// leaves on m_tvalid/m_tready/m_tdata in the same order. The car width and
// length are written on the cfg_valid/cfg_index/cfg_data port, which always
// accepts; write them only while no item is in flight.
// Throughput is one item per clock while the output is not stalled. Between
// the edge that accepted an input and its result lie four stages for angle,
// cotangent table, inner radius and middle radius, FRAC_BITS + 7 stages of
// the two restoring dividers (one quotient bit per stage), one multiply stage
// and the output register.
// Reset clears the car width and length to zero and empties the pipeline.
// When the receiver stalls, the output register holds its item; the pipeline
// keeps moving and accepting items until its last stage holds an item that
// cannot leave, and only then is s_tready dropped.
module steering_wheel_speed_split #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [15:0] drive_speed, [23:16] steer_angle
    input  logic [swss_pkg::S_TDATA_W-1:0]        s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [15:0] left_speed, [31:16] right_speed
    output logic [swss_pkg::M_TDATA_W-1:0]        m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [swss_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [swss_pkg::CFG_W-1:0]            cfg_data
);

    localparam int ROM_W  = FRAC_BITS + 6;
    localparam int MID_W  = FRAC_BITS + 15;
    localparam int DVD_W  = MID_W + FRAC_BITS;
    localparam int Q_W    = FRAC_BITS + 7;
    localparam int PROD_W = swss_pkg::SPEED_W + Q_W;
    localparam int P_W    = PROD_W - FRAC_BITS;

    localparam logic [P_W-1:0] NEG_LIMIT = P_W'(32768);
    localparam logic [P_W-1:0] POS_LIMIT = P_W'(32767);
    localparam logic [Q_W-1:0] ONE_FACTOR = Q_W'(1) << FRAC_BITS;

    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    // ------------------------------------------------------------------
    // Cotangent table, built at elaboration with 62-bit fixed point series.
    // ------------------------------------------------------------------
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] cot_q(input int d);
        logic [63:0] dd;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] ts;
        logic [63:0] tc;
        logic [63:0] s38;
        logic [63:0] c38;
        if (d == 0 || d == swss_pkg::MAX_DEG) begin
            return '0;
        end
        dd = 64'(d);
        x  = (PI_Q62 / 64'd180) * dd + ((PI_Q62 % 64'd180) * dd) / 64'd180;
        x2 = mul_q62(x, x);
        s  = x;
        c  = ONE_Q62;
        ts = x;
        tc = ONE_Q62;
        for (int k = 1; k <= 30; k++) begin
            ts = udiv64(mul_q62(ts, x2), 64'((2 * k) * (2 * k + 1)));
            tc = udiv64(mul_q62(tc, x2), 64'((2 * k - 1) * (2 * k)));
            if ((k % 2) == 1) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        s38 = s >> 24;
        c38 = c >> 24;
        return udiv64((c38 << FRAC_BITS) + (s38 >> 1), s38);
    endfunction

    logic [ROM_W-1:0] cot_rom [0:swss_pkg::MAX_DEG];

    for (genvar g = 0; g <= swss_pkg::MAX_DEG; g++) begin : g_cot
        localparam logic [63:0] COT_VAL = cot_q(g);
        assign cot_rom[g] = COT_VAL[ROM_W-1:0];
    end

    // Truncates the scaled product, restores the sign and saturates.
    function automatic logic [swss_pkg::SPEED_W-1:0] scale_speed(
        input logic [PROD_W-1:0] prod,
        input logic              neg
    );
        logic [P_W-1:0]               p;
        logic [swss_pkg::SPEED_W-1:0] m;
        p = prod[PROD_W-1:FRAC_BITS];
        if (neg) begin
            m = (p > NEG_LIMIT) ? 16'h8000 : p[swss_pkg::SPEED_W-1:0];
            return ~m + 16'd1;
        end
        m = (p > POS_LIMIT) ? 16'h7FFF : p[swss_pkg::SPEED_W-1:0];
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [swss_pkg::CFG_W-1:0] car_width_reg;
    logic [swss_pkg::CFG_W-1:0] car_width_next;
    logic [swss_pkg::CFG_W-1:0] car_length_reg;
    logic [swss_pkg::CFG_W-1:0] car_length_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        car_width_next  = car_width_reg;
        car_length_next = car_length_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                swss_pkg::REG_CAR_WIDTH:  car_width_next  = cfg_data;
                swss_pkg::REG_CAR_LENGTH: car_length_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            car_width_reg  <= '0;
            car_length_reg <= '0;
        end else begin
            car_width_reg  <= car_width_next;
            car_length_reg <= car_length_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything advances together unless the last stage
    // holds an item and the output register cannot take it.
    // ------------------------------------------------------------------
    logic en;
    logic out_load;
    logic s5_valid_reg;
    logic m_valid_reg;

    assign out_load = !m_valid_reg || m_tready;
    assign en       = out_load || !s5_valid_reg;
    assign s_tready = en;

    // Stage 1: angle magnitude, clamp, speed magnitude.
    logic                          s1_valid_reg;
    swss_pkg::side_t               s1_side_reg;
    swss_pkg::side_t               s1_side_next;
    logic [swss_pkg::DEG_W-1:0]    s1_deg_reg;
    logic [swss_pkg::DEG_W-1:0]    s1_deg_next;

    logic signed [swss_pkg::SPEED_W-1:0] in_speed;
    logic signed [swss_pkg::ANGLE_W-1:0] in_angle;
    logic [swss_pkg::ANGLE_W-1:0]        angle_abs;

    always_comb begin
        in_speed  = s_tdata[15:0];
        in_angle  = s_tdata[23:16];
        angle_abs = in_angle[7] ? (~s_tdata[23:16] + 8'd1) : s_tdata[23:16];
        s1_deg_next = (angle_abs > 8'(swss_pkg::MAX_DEG)) ?
                      swss_pkg::DEG_W'(swss_pkg::MAX_DEG) : angle_abs[swss_pkg::DEG_W-1:0];
        s1_side_next.speed      = in_speed;
        s1_side_next.neg        = in_speed[15];
        s1_side_next.mag        = in_speed[15] ? (~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
        s1_side_next.turn_right = !in_angle[7] && (in_angle != 8'sd0);
        s1_side_next.bypass     = (in_angle == 8'sd0);
    end

    // Stage 2: cotangent lookup.
    logic             s2_valid_reg;
    swss_pkg::side_t  s2_side_reg;
    logic [ROM_W-1:0] s2_cot_reg;
    logic [ROM_W-1:0] s2_cot_next;

    assign s2_cot_next = cot_rom[s1_deg_reg];

    // Stage 3: inner radius.
    logic                                s3_valid_reg;
    swss_pkg::side_t                     s3_side_reg;
    logic [ROM_W+swss_pkg::CFG_W-1:0]    s3_inner_reg;
    logic [ROM_W+swss_pkg::CFG_W-1:0]    s3_inner_next;

    assign s3_inner_next = (ROM_W + swss_pkg::CFG_W)'(s2_cot_reg) *
                           (ROM_W + swss_pkg::CFG_W)'(car_length_reg);

    // Stage 4: middle radius and the two numerators.
    logic             s4_valid_reg;
    swss_pkg::side_t  s4_side_reg;
    swss_pkg::side_t  s4_side_next;
    logic [MID_W-1:0] s4_mid_reg;
    logic [MID_W-1:0] s4_mid_next;
    logic [MID_W-1:0] s4_outer_reg;
    logic [MID_W-1:0] s4_outer_next;
    logic [MID_W-1:0] s4_inner_reg;
    logic [MID_W-1:0] s4_inner_next;

    always_comb begin
        s4_inner_next = MID_W'(s3_inner_reg);
        s4_mid_next   = s4_inner_next + (MID_W'(car_width_reg[7:1]) << FRAC_BITS);
        s4_outer_next = s4_inner_next + (MID_W'(car_width_reg) << FRAC_BITS);
        s4_side_next  = s3_side_reg;
        // A zero middle radius passes the speed through unchanged.
        s4_side_next.bypass = s3_side_reg.bypass || (s4_mid_next == '0);
    end

    // Divider stages, with the side data carried in step.
    logic [Q_W-1:0] q_outer;
    logic [Q_W-1:0] q_inner;

    swss_div #(.DVD_W(DVD_W), .DVS_W(MID_W), .Q_W(Q_W)) u_div_outer (
        .aclk     (aclk),
        .en       (en),
        .dividend ({s4_outer_reg, FRAC_BITS'(0)}),
        .divisor  (s4_mid_reg),
        .quotient (q_outer)
    );

    swss_div #(.DVD_W(DVD_W), .DVS_W(MID_W), .Q_W(Q_W)) u_div_inner (
        .aclk     (aclk),
        .en       (en),
        .dividend ({s4_inner_reg, FRAC_BITS'(0)}),
        .divisor  (s4_mid_reg),
        .quotient (q_inner)
    );

    logic            dv_valid_reg [0:Q_W-1];
    swss_pkg::side_t dv_side_reg  [0:Q_W-1];

    for (genvar i = 0; i < Q_W; i++) begin : g_side
        logic            dv_valid_next;
        swss_pkg::side_t dv_side_next;

        if (i == 0) begin : g_first
            assign dv_valid_next = s4_valid_reg;
            assign dv_side_next  = s4_side_reg;
        end else begin : g_rest
            assign dv_valid_next = dv_valid_reg[i-1];
            assign dv_side_next  = dv_side_reg[i-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[i] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[i] <= dv_valid_next;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_side_reg[i] <= dv_side_next;
            end
        end
    end

    // Stage 5: speed times factor.
    swss_pkg::side_t   s5_side_reg;
    logic [PROD_W-1:0] s5_prod_out_reg;
    logic [PROD_W-1:0] s5_prod_out_next;
    logic [PROD_W-1:0] s5_prod_in_reg;
    logic [PROD_W-1:0] s5_prod_in_next;

    assign s5_prod_out_next = PROD_W'(dv_side_reg[Q_W-1].mag) * PROD_W'(q_outer);
    assign s5_prod_in_next  = PROD_W'(dv_side_reg[Q_W-1].mag) * PROD_W'(q_inner);

    // Output register.
    logic [swss_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [swss_pkg::M_TDATA_W-1:0] m_data_next;
    logic [swss_pkg::SPEED_W-1:0]   outer_speed;
    logic [swss_pkg::SPEED_W-1:0]   inner_speed;

    always_comb begin
        outer_speed = scale_speed(s5_prod_out_reg, s5_side_reg.neg);
        inner_speed = scale_speed(s5_prod_in_reg, s5_side_reg.neg);
        if (s5_side_reg.bypass) begin
            m_data_next = {s5_side_reg.speed, s5_side_reg.speed};
        end else if (s5_side_reg.turn_right) begin
            m_data_next = {inner_speed, outer_speed};
        end else begin
            m_data_next = {outer_speed, inner_speed};
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= dv_valid_reg[Q_W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= s5_valid_reg;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg     <= s1_side_next;
            s1_deg_reg      <= s1_deg_next;
            s2_side_reg     <= s1_side_reg;
            s2_cot_reg      <= s2_cot_next;
            s3_side_reg     <= s2_side_reg;
            s3_inner_reg    <= s3_inner_next;
            s4_side_reg     <= s4_side_next;
            s4_mid_reg      <= s4_mid_next;
            s4_outer_reg    <= s4_outer_next;
            s4_inner_reg    <= s4_inner_next;
            s5_side_reg     <= dv_side_reg[Q_W-1];
            s5_prod_out_reg <= s5_prod_out_next;
            s5_prod_in_reg  <= s5_prod_in_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_valid_reg && !m_tready && s5_valid_reg))
        else $error("input stalled although the pipeline could advance");

    a_inner_factor_le_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (dv_valid_reg[Q_W-1] && !dv_side_reg[Q_W-1].bypass) |-> (q_inner <= ONE_FACTOR))
        else $error("inner wheel factor above one");

    a_inner_le_outer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s5_valid_reg && !s5_side_reg.bypass) |-> (s5_prod_in_reg <= s5_prod_out_reg))
        else $error("inner wheel product exceeds outer wheel product");

    a_bypass_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && s5_valid_reg && s5_side_reg.bypass) |=>
        (m_tdata[15:0] == m_tdata[31:16]))
        else $error("straight-ahead item gave different wheel speeds");

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC    = 14;
    localparam int LATENCY = FRAC + 12;
    localparam int RAND_PHASES   = 12;
    localparam int ITEMS_PER_SET = 150;

    localparam logic [swss_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [swss_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam bit [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam bit [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef struct packed {
        logic signed [swss_pkg::ANGLE_W-1:0] angle;
        logic signed [swss_pkg::SPEED_W-1:0] speed;
    } drive_cmd_t;

    typedef struct packed {
        logic signed [swss_pkg::SPEED_W-1:0] right;
        logic signed [swss_pkg::SPEED_W-1:0] left;
    } wheel_pair_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    drive_cmd_t                     s_tdata = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    wheel_pair_t                    m_tdata;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [swss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [swss_pkg::CFG_W-1:0]     cfg_data = '0;

    steering_wheel_speed_split #(.FRAC_BITS(FRAC)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the geometry registers and the cotangent table.
    logic [swss_pkg::CFG_W-1:0] track_mm = '0;
    logic [swss_pkg::CFG_W-1:0] base_mm = '0;
    bit [63:0]                  cot_table [0:swss_pkg::MAX_DEG];

    drive_cmd_t  drive_cmds[$];
    wheel_pair_t pending_wheels[$];

    bit no_idle = 1'b0;
    int issued_total = 0;
    int accepted_total = 0;
    int checked_total = 0;
    int err_count = 0;
    int geometry_count = 0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    function automatic bit [63:0] qmul62(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Sine and cosine by a 30-term Taylor series in Q62, then cot in Q(FRAC)
    // rounded to nearest from the top 38 bits of each.
    function automatic void build_cot_table();
        bit [63:0] x, x2, s, c, ts, tc, s38, c38, d, k;
        cot_table[0] = '0;
        for (d = 1; d <= swss_pkg::MAX_DEG; d++) begin
            x  = (PI_Q62 / 180) * d + ((PI_Q62 % 180) * d) / 180;
            x2 = qmul62(x, x);
            s  = x;
            c  = ONE_Q62;
            ts = x;
            tc = ONE_Q62;
            for (k = 1; k <= 30; k++) begin
                ts = qmul62(ts, x2) / ((2 * k) * (2 * k + 1));
                tc = qmul62(tc, x2) / ((2 * k - 1) * (2 * k));
                if (k[0]) begin
                    s = s - ts;
                    c = c - tc;
                end else begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            if (d == swss_pkg::MAX_DEG) begin
                cot_table[swss_pkg::DEG_W'(d)] = '0;
            end else begin
                s38 = s >> 24;
                c38 = c >> 24;
                cot_table[swss_pkg::DEG_W'(d)] = ((c38 << FRAC) + (s38 >> 1)) / s38;
            end
        end
    endfunction

    function automatic logic signed [swss_pkg::SPEED_W-1:0] scale_wheel(
        logic signed [swss_pkg::SPEED_W-1:0] spd,
        bit [63:0]                           factor
    );
        int        sv;
        bit [63:0] mag, p, cap;
        sv  = spd;
        mag = (sv < 0) ? 64'(-sv) : 64'(sv);
        cap = 64'd1 << (FRAC + 17);
        if (factor > cap) begin
            factor = cap;
        end
        p = (mag * factor) >> FRAC;
        if (sv < 0) begin
            if (p > 32768) begin
                p = 32768;
            end
            return 16'(64'd0 - p);
        end
        if (p > 32767) begin
            p = 32767;
        end
        return 16'(p);
    endfunction

    function automatic wheel_pair_t split_speed(drive_cmd_t cmd);
        wheel_pair_t r;
        int          deg;
        bit [63:0]   inner, middle, outer_f, inner_f;
        logic signed [swss_pkg::SPEED_W-1:0] outer_s, inner_s;
        r.left  = cmd.speed;
        r.right = cmd.speed;
        if (cmd.angle == 0) begin
            return r;
        end
        deg = int'(cmd.angle);
        if (deg < 0) begin
            deg = -deg;
        end
        if (deg > swss_pkg::MAX_DEG) begin
            deg = swss_pkg::MAX_DEG;
        end
        inner  = cot_table[swss_pkg::DEG_W'(deg)] * 64'(base_mm);
        middle = inner + (64'(track_mm >> 1) << FRAC);
        // Degenerate geometry: no turning radius, both wheels follow the speed.
        if (middle == 0) begin
            return r;
        end
        outer_f = ((inner + (64'(track_mm) << FRAC)) << FRAC) / middle;
        inner_f = (inner << FRAC) / middle;
        outer_s = scale_wheel(cmd.speed, outer_f);
        inner_s = scale_wheel(cmd.speed, inner_f);
        if (cmd.angle > 0) begin
            r.left  = outer_s;
            r.right = inner_s;
        end else begin
            r.left  = inner_s;
            r.right = outer_s;
        end
        return r;
    endfunction

    task automatic queue_cmd(input int spd, input int ang);
        drive_cmd_t c;
        c.speed = 16'(spd);
        c.angle = 8'(ang);
        drive_cmds.push_back(c);
        issued_total++;
    endtask

    task automatic write_reg(input logic [swss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [swss_pkg::CFG_W-1:0]     val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            swss_pkg::REG_CAR_WIDTH: begin
                track_mm = val;
            end
            swss_pkg::REG_CAR_LENGTH: begin
                base_mm = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic write_geometry(input logic [swss_pkg::CFG_W-1:0] track,
                                  input logic [swss_pkg::CFG_W-1:0] base);
        write_reg(swss_pkg::REG_CAR_WIDTH, track);
        write_reg(swss_pkg::REG_CAR_LENGTH, base);
        geometry_count++;
    endtask

    task automatic settle();
        while (checked_total != issued_total) begin
            @(posedge aclk);
        end
        @(posedge aclk);
    endtask

    // Input side: holds an item until it is taken, predicts it on acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pending_wheels.push_back(split_speed(s_tdata));
                accepted_total++;
            end
            if (!s_tvalid || s_tready) begin
                if (drive_cmds.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= drive_cmds.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: random backpressure and in-order comparison.
    always @(posedge aclk) begin
        wheel_pair_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_idle || ($urandom_range(99) >= 37);
            if (m_tvalid && m_tready) begin
                if (pending_wheels.size() == 0) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("unexpected result item: left %0d right %0d",
                                 m_tdata.left, m_tdata.right);
                    end
                end else begin
                    want = pending_wheels.pop_front();
                    checked_total++;
                    if (m_tdata.left !== want.left || m_tdata.right !== want.right) begin
                        err_count++;
                        if (err_count <= 10) begin
                            $display("bad item %0d: expected L %0d R %0d, got L %0d R %0d",
                                     checked_total, want.left, want.right,
                                     m_tdata.left, m_tdata.right);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int spd;
        int ang;
        logic [swss_pkg::CFG_W-1:0] trk;
        logic [swss_pkg::CFG_W-1:0] bse;

        build_cot_table();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers still at reset: every angle passes the speed straight through.
        queue_cmd(1000, 0);
        queue_cmd(-32768, 45);
        queue_cmd(32767, -128);
        queue_cmd(-1, 90);
        settle();

        // Widest and longest car; writes to unused indexes must change nothing.
        write_geometry(8'd255, 8'd255);
        write_reg(REG_SPARE_A, 8'hAA);
        write_reg(REG_SPARE_B, 8'h55);
        queue_cmd(32767, 1);
        queue_cmd(-32768, 1);
        queue_cmd(32767, -1);
        queue_cmd(-32768, -1);
        queue_cmd(0, 1);
        queue_cmd(12345, 45);
        queue_cmd(-12345, -45);
        queue_cmd(32767, 127);
        queue_cmd(-32768, -128);
        queue_cmd(1000, 91);
        queue_cmd(1000, -91);
        queue_cmd(1000, 90);
        queue_cmd(1000, -90);
        queue_cmd(-1, 30);
        queue_cmd(1, -30);
        settle();

        // Width 1 halves to zero, so at ninety degrees the middle radius vanishes.
        write_geometry(8'd1, 8'd200);
        queue_cmd(5000, 90);
        queue_cmd(-5000, -90);
        queue_cmd(5000, 89);
        settle();

        // Tiny middle radius gives the largest outer factor; zero speed stays zero.
        write_geometry(8'd1, 8'd1);
        queue_cmd(0, 89);
        queue_cmd(32767, 89);
        queue_cmd(-32768, -89);
        queue_cmd(1, 89);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin trk = 8'd255; bse = 8'd0;   end
                1: begin trk = 8'd0;   bse = 8'd255; end
                2: begin trk = 8'd1;   bse = 8'd1;   end
                3: begin trk = 8'd2;   bse = 8'd1;   end
                4: begin trk = 8'd255; bse = 8'd1;   end
                5: begin trk = 8'd1;   bse = 8'd255; end
                default: begin
                    trk = 8'($urandom_range(255));
                    bse = 8'($urandom_range(255));
                end
            endcase
            write_geometry(trk, bse);
            if (ph == 7) begin
                write_reg(($urandom_range(1) != 0) ? REG_SPARE_A : REG_SPARE_B,
                          8'($urandom_range(255)));
            end
            no_idle = (ph == 6);
            for (int i = 0; i < ITEMS_PER_SET; i++) begin
                case ($urandom_range(9))
                    0: begin
                        case ($urandom_range(4))
                            0: spd = 32767;
                            1: spd = -32768;
                            2: spd = 0;
                            3: spd = -1;
                            default: spd = 1;
                        endcase
                    end
                    1, 2, 3: spd = int'($urandom_range(4000)) - 2000;
                    default: spd = int'($urandom_range(65535)) - 32768;
                endcase
                case ($urandom_range(9))
                    6: ang = 0;
                    7: ang = ($urandom_range(1) != 0) ? 90 : -90;
                    8, 9: ang = int'($urandom_range(255)) - 128;
                    default: ang = int'($urandom_range(180)) - 90;
                endcase
                queue_cmd(spd, ang);
            end
            settle();
            no_idle = 1'b0;
        end

        while (checked_total != issued_total) begin
            @(posedge aclk);
        end
        repeat (2 * LATENCY) @(posedge aclk);

        $display("Covered %0d drive items over %0d car geometries, %0d wheel results checked.",
                 accepted_total, geometry_count + 1, checked_total);
        $display("Found %0d bad result items, %0d expected results left over.",
                 err_count, pending_wheels.size());
        if (err_count == 0 && pending_wheels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
